@@ src/tlf_pkg.sv @@
package tlf_pkg;

	// Character and register widths
	localparam int CHAR_W  = 8;
	localparam int LIMIT_W = 12;

	// Blank codes
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd40;

	// Held blank buffer: at most HOLD_DEPTH-1 entries are ever in use
	localparam int HOLD_DEPTH = 64;
	localparam int HOLD_AW    = $clog2(HOLD_DEPTH);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// One command: optional leading newline or error, a flush of held
	// blanks, then an optional trailing character
	typedef struct packed {
		logic                first_en;
		logic                first_err;
		logic [HOLD_AW-1:0]  flush_cnt;
		logic                tail_en;
		logic [CHAR_W-1:0]   tail_char;
	} cmd_t;

	// Write into the held blank buffer
	typedef struct packed {
		logic               en;
		logic [HOLD_AW-1:0] addr;
		logic [CHAR_W-1:0]  data;
	} hold_wr_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FIRST,
		B_FLUSH,
		B_TAIL
	} back_state_t;

endpackage

@@ src/text_line_folder.sv @@
// Throughput: one result per cycle while m_tready is high; an item that flushes n held blanks gives up to
// n+1 results, and input stalls until the back has read the held buffer out.
// A two-entry command queue parts the input side from the result side.
// Reset (arst_n low) clears column, held count, halt flag, queue and output;
// the line limit returns to 40. The held blank buffer is not cleared.
module text_line_folder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // in_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // out_char
	output logic        m_tuser,     // overflow_error
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data  // line_limit
);
	import tlf_pkg::*;

	cmd_t     push_cmd;
	cmd_t     pop_cmd;
	hold_wr_t hold_wr;
	logic     cmd_push;
	logic     q_full;
	logic     q_empty;
	logic     q_pop;
	logic     flush_done;

	// Classify items
	tlf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (push_cmd),
		.cmd_push    (cmd_push),
		.q_full      (q_full),
		.hold_wr     (hold_wr),
		.flush_done  (flush_done)
	);

	// Buffer commands
	tlf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// Emit results
	tlf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_cmd      (pop_cmd),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.hold_wr    (hold_wr),
		.flush_done (flush_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

@@ src/tlf_front.sv @@
module tlf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,    // in_char
	input  logic                      cfg_wr_en,
	input  logic [11:0]               cfg_wr_data, // line_limit
	output tlf_pkg::cmd_t             cmd,
	output logic                      cmd_push,
	input  logic                      q_full,
	output tlf_pkg::hold_wr_t         hold_wr,
	input  logic                      flush_done
);
	import tlf_pkg::*;

	logic [LIMIT_W-1:0] line_limit_q;
	logic [LIMIT_W-1:0] column_q, column_d, column_inc;
	logic [HOLD_AW-1:0] held_count_q, held_count_d;
	logic               halted_q, halted_d;
	logic               lock_q;
	logic               accept;
	logic               is_blank;

	// Stall while the queue is full or the back reads the held buffer
	assign s_tready = !q_full && !lock_q;
	assign accept   = s_tvalid && s_tready;
	assign is_blank = (s_tdata == CHAR_SPACE) || (s_tdata == CHAR_TAB) ||
	                  (s_tdata == CHAR_NEWLINE);

	// Saturating column advance
	assign column_inc = (column_q == '1) ? column_q : column_q + 1'b1;

	// Classify the item and build its command
	always_comb begin
		cmd          = '0;
		cmd_push     = 1'b0;
		hold_wr      = '0;
		column_d     = column_q;
		held_count_d = held_count_q;
		halted_d     = halted_q;
		if (accept && !halted_q) begin
			if (!is_blank) begin
				cmd.flush_cnt = held_count_q;
				cmd.tail_en   = 1'b1;
				cmd.tail_char = s_tdata;
				cmd_push      = 1'b1;
				held_count_d  = '0;
				column_d      = column_inc;
			end else if (column_q < line_limit_q) begin
				if (held_count_q != HOLD_AW'(HOLD_DEPTH - 1)) begin
					hold_wr.en   = 1'b1;
					hold_wr.addr = held_count_q;
					hold_wr.data = s_tdata;
					if (s_tdata == CHAR_NEWLINE) begin
						cmd.flush_cnt = held_count_q + 1'b1;
						cmd_push      = 1'b1;
						held_count_d  = '0;
						column_d      = '0;
					end else begin
						held_count_d = held_count_q + 1'b1;
						column_d     = column_inc;
					end
				end else begin
					cmd.first_en  = 1'b1;
					cmd.first_err = 1'b1;
					cmd_push      = 1'b1;
					halted_d      = 1'b1;
				end
			end else begin
				cmd.first_en  = 1'b1;
				cmd.flush_cnt = held_count_q;
				cmd_push      = 1'b1;
				held_count_d  = '0;
				column_d      = '0;
			end
		end
	end

	// Hold state and line limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LIMIT_RESET;
			column_q     <= '0;
			held_count_q <= '0;
			halted_q     <= 1'b0;
			lock_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				line_limit_q <= cfg_wr_data;
			end
			column_q     <= column_d;
			held_count_q <= held_count_d;
			halted_q     <= halted_d;
			if (cmd_push && cmd.flush_cnt != '0) begin
				lock_q <= 1'b1;
			end else if (flush_done) begin
				lock_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/tlf_queue.sv @@
module tlf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tlf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output tlf_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import tlf_pkg::*;

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push, do_pop;

	assign full    = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/tlf_back.sv @@
module tlf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tlf_pkg::cmd_t     q_cmd,
	input  logic              q_empty,
	output logic              q_pop,
	input  tlf_pkg::hold_wr_t hold_wr,
	output logic              flush_done,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,    // out_char
	output logic              m_tuser,    // overflow_error
	output logic              m_tlast
);
	import tlf_pkg::*;

	back_state_t        state_q, state_d;
	cmd_t               cmd_q;
	logic [HOLD_AW-1:0] idx_q, idx_d;
	logic [CHAR_W-1:0]  hold_mem [HOLD_DEPTH];
	logic [CHAR_W-1:0]  rd_data_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_err_q;
	logic               out_last_q;
	logic               emit;
	logic               done;
	logic               load;
	logic               flush_end;
	logic [CHAR_W-1:0]  res_char;
	logic               res_err;
	logic               res_last;

	assign emit      = (state_q != B_IDLE) && (!out_valid_q || m_tready);
	assign flush_end = (idx_q == HOLD_AW'(cmd_q.flush_cnt - 1'b1));

	// Pick the result of the current step
	always_comb begin
		res_char = CHAR_NUL;
		res_err  = 1'b0;
		res_last = 1'b0;
		case (state_q)
			B_FIRST: begin
				res_char = cmd_q.first_err ? CHAR_NUL : CHAR_NEWLINE;
				res_err  = cmd_q.first_err;
				res_last = (cmd_q.flush_cnt == '0) && !cmd_q.tail_en;
			end
			B_FLUSH: begin
				res_char = rd_data_q;
				res_last = flush_end && !cmd_q.tail_en;
			end
			B_TAIL: begin
				res_char = cmd_q.tail_char;
				res_last = 1'b1;
			end
			default: begin
				res_char = CHAR_NUL;
			end
		endcase
	end

	assign done       = emit && res_last;
	assign load       = ((state_q == B_IDLE) || done) && !q_empty;
	assign q_pop      = load;
	assign flush_done = done && (cmd_q.flush_cnt != '0);

	// Sequence the steps of a command
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		if (load) begin
			idx_d = '0;
			if (q_cmd.first_en) begin
				state_d = B_FIRST;
			end else if (q_cmd.flush_cnt != '0) begin
				state_d = B_FLUSH;
			end else begin
				state_d = B_TAIL;
			end
		end else if (done) begin
			state_d = B_IDLE;
		end else if (emit) begin
			case (state_q)
				B_FIRST: begin
					state_d = (cmd_q.flush_cnt != '0) ? B_FLUSH : B_TAIL;
				end
				B_FLUSH: begin
					if (flush_end) begin
						state_d = B_TAIL;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				default: begin
					state_d = B_IDLE;
				end
			endcase
		end
	end

	// Held blank buffer, read one entry ahead
	always_ff @(posedge clk) begin
		if (hold_wr.en) begin
			hold_mem[hold_wr.addr] <= hold_wr.data;
		end
		rd_data_q <= hold_mem[idx_d];
	end

	// Load the command and the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_cmd;
		end
		if (emit) begin
			out_char_q <= res_char;
			out_err_q  <= res_err;
			out_last_q <= res_last;
		end
	end

	// Control state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

endmodule
